[hdl/debounced_pulse_counter_defines.svh]
// Assertion macros used by the debounced pulse counter top level.
`ifndef DEBOUNCED_PULSE_COUNTER_DEFINES_SVH
`define DEBOUNCED_PULSE_COUNTER_DEFINES_SVH

// Clocked check, masked while reset is high.
`define DPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds across reset.
`define DPC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/dpc_pkg.sv]
// Types and constants of the debounced pulse counter.
package dpc_pkg;

  localparam int CountW = 31;
  localparam int SecsW  = 32;
  localparam int MinW   = 16;
  localparam int StableW = 17;

  // register word indexes (byte address 4*i)
  localparam logic [1:0] REG_COUNT_HIGH = 2'd0;
  localparam logic [1:0] REG_MIN_PULSE  = 2'd1;
  localparam logic [1:0] REG_MAX_COUNT  = 2'd2;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef struct packed {
    logic              op;
    logic              pin_level;
    logic [CountW-1:0] clear_value;
  } item_t;

  typedef struct packed {
    logic [CountW-1:0] pulse_count;
    logic [SecsW-1:0]  high_seconds;
    logic              debounced_level;
    logic              raw_level;
  } result_t;

  typedef struct packed {
    logic              count_high;
    logic [MinW-1:0]   min_pulse_ticks;
    logic [CountW-1:0] max_count;
  } cfg_t;

endpackage

[hdl/debounced_pulse_counter.sv]
// Flow: an accepted beat passes from the input register into the result register once that register is free.
// Throughput: one beat per cycle while the result register is not stalled; the state update is
//   combinational compare and increment logic between the input register and result register.
// Reset (rst, synchronous): all state, counts and timers clear, count_high
//   goes to 1, min_pulse_ticks and max_count to 0, both pipeline stages empty.
// Top level of the debounced pulse counter: APB registers and item pipeline.
`include "debounced_pulse_counter_defines.svh"

module debounced_pulse_counter #(
  parameter int TICKS_PER_SECOND = 1000
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  dpc_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output dpc_pkg::result_t result,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import dpc_pkg::*;

  cfg_t       cfg;
  logic       cfg_write;
  logic [1:0] reg_index;

  item_t      s1_item;
  logic       s1_valid;
  logic       advance;
  result_t    result_next;

  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.count_high      <= 1'b1;
      cfg.min_pulse_ticks <= '0;
      cfg.max_count       <= '0;
    end else if (cfg_write) begin
      unique case (reg_index)
        REG_COUNT_HIGH: cfg.count_high      <= pwdata[0];
        REG_MIN_PULSE:  cfg.min_pulse_ticks <= pwdata[MinW-1:0];
        REG_MAX_COUNT:  cfg.max_count       <= pwdata[CountW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_COUNT_HIGH: prdata = {31'd0, cfg.count_high};
      REG_MIN_PULSE:  prdata = {16'd0, cfg.min_pulse_ticks};
      REG_MAX_COUNT:  prdata = {1'b0, cfg.max_count};
      default:        prdata = '0;
    endcase
  end

  // move the staged beat into the result register whenever that register is free
  assign advance    = s1_valid && (!result_valid || !result_stall);
  assign item_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!item_stall) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      s1_item <= item;
    end
  end

  dpc_core #(
    .TICKS_PER_SECOND(TICKS_PER_SECOND)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .pol_load   (cfg_write && (reg_index == REG_COUNT_HIGH)),
    .pol_value  (pwdata[0]),
    .step       (advance),
    .item       (s1_item),
    .result_next(result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  `DPC_ASSERT(a_no_accept_when_full,
              (s1_valid && result_valid && result_stall) |-> item_stall,
              "beat accepted with both stages full")
  `DPC_ASSERT(a_advance_fills_result, advance |=> result_valid,
              "advanced beat missing from result register")
  `DPC_ASSERT(a_clear_zeroes_secs,
              (advance && s1_item.op == OP_CLEAR) |=> (result.high_seconds == '0),
              "clear left high seconds nonzero")
  `DPC_ASSERT_RST(a_reset_empties, rst |=> (!result_valid && !s1_valid),
                  "pipeline not empty after reset")

endmodule

[hdl/dpc_core.sv]
// Debounce, pulse count and high-time state with its next-state logic.
module dpc_core #(
  parameter int TICKS_PER_SECOND = 1000
) (
  input  logic             clk,
  input  logic             rst,
  input  dpc_pkg::cfg_t    cfg,
  input  logic             pol_load,
  input  logic             pol_value,
  input  logic             step,
  input  dpc_pkg::item_t   item,
  output dpc_pkg::result_t result_next
);
  import dpc_pkg::*;

  localparam int HtW = $clog2(TICKS_PER_SECOND + 2);
  localparam logic [HtW-1:0] TpsVal = HtW'(TICKS_PER_SECOND);
  // whole seconds and remainder when the tick count first passes one second
  localparam logic [SecsW:0]  SecAdd = (SecsW+1)'((TICKS_PER_SECOND + 1) / TICKS_PER_SECOND);
  localparam logic [HtW-1:0]  TickRem = HtW'((TICKS_PER_SECOND + 1) % TICKS_PER_SECOND);

  logic               last_level, last_level_next;
  logic               edge_rising, edge_rising_next;
  logic               settled, settled_next;
  logic [StableW-1:0] stable_ticks, stable_ticks_next;
  logic               accepted_level, accepted_level_next;
  logic [CountW-1:0]  count, count_next;
  logic [HtW-1:0]     high_ticks, high_ticks_next;
  logic [SecsW-1:0]   high_secs, high_secs_next;

  logic [StableW-1:0] stable_inc;
  logic [HtW-1:0]     ht_inc;
  logic [SecsW:0]     secs_sum;

  assign stable_inc = stable_ticks + StableW'(1);
  assign ht_inc     = high_ticks + HtW'(1);
  assign secs_sum   = {1'b0, high_secs} + SecAdd;

  always_comb begin
    last_level_next     = last_level;
    edge_rising_next    = edge_rising;
    settled_next        = settled;
    stable_ticks_next   = stable_ticks;
    accepted_level_next = accepted_level;
    count_next          = count;
    high_ticks_next     = high_ticks;
    high_secs_next      = high_secs;
    if (item.op == OP_CLEAR) begin
      count_next        = item.clear_value;
      last_level_next   = cfg.count_high;
      edge_rising_next  = ~cfg.count_high;
      high_ticks_next   = '0;
      high_secs_next    = '0;
      stable_ticks_next = '0;
      settled_next      = 1'b0;
    end else if (item.pin_level != last_level) begin
      // level changed: restart the stability timer, note the edge
      stable_ticks_next = '0;
      settled_next      = 1'b0;
      edge_rising_next  = ~last_level;
      last_level_next   = item.pin_level;
    end else if (!settled) begin
      stable_ticks_next = stable_inc;
      if (stable_inc > {1'b0, cfg.min_pulse_ticks}) begin
        accepted_level_next = last_level;
        if (edge_rising == cfg.count_high) begin
          count_next = (count >= cfg.max_count) ? CountW'(1) : count + CountW'(1);
        end
        stable_ticks_next = '0;
        settled_next      = 1'b1;
      end
    end else if (edge_rising) begin
      high_ticks_next = ht_inc;
      if (ht_inc > TpsVal) begin
        high_secs_next  = secs_sum[SecsW] ? '1 : secs_sum[SecsW-1:0];
        high_ticks_next = TickRem;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_level     <= 1'b0;
      edge_rising    <= 1'b0;
      settled        <= 1'b0;
      stable_ticks   <= '0;
      accepted_level <= 1'b0;
      count          <= '0;
      high_ticks     <= '0;
      high_secs      <= '0;
    end else if (pol_load) begin
      last_level  <= pol_value;
      edge_rising <= ~pol_value;
    end else if (step) begin
      last_level     <= last_level_next;
      edge_rising    <= edge_rising_next;
      settled        <= settled_next;
      stable_ticks   <= stable_ticks_next;
      accepted_level <= accepted_level_next;
      count          <= count_next;
      high_ticks     <= high_ticks_next;
      high_secs      <= high_secs_next;
    end
  end

  assign result_next.pulse_count     = count_next;
  assign result_next.high_seconds    = high_secs_next;
  assign result_next.debounced_level = accepted_level_next;
  assign result_next.raw_level       = last_level_next;

endmodule
